### rtl/tobuf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the time-ordered packet buffer.
// No dependencies.
package tobuf_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int TAG_BITS_DEF = 32;

  localparam int TIME_W = 63;
  localparam int TAG_W  = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 4;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 7'd64;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam func_t FN_INSERT = 2'd0;
  localparam func_t FN_EXPIRE = 2'd1;
  localparam func_t FN_QUERY  = 2'd2;

  localparam status_t STS_BACK   = 4'd0;
  localparam status_t STS_FRONT  = 4'd1;
  localparam status_t STS_MIDDLE = 4'd2;
  localparam status_t STS_DUP    = 4'd3;
  localparam status_t STS_OLD    = 4'd4;
  localparam status_t STS_EXPIRE = 4'd5;
  localparam status_t STS_HIT    = 4'd6;
  localparam status_t STS_EMPTY  = 4'd7;
  localparam status_t STS_BADRNG = 4'd8;

endpackage

### rtl/tobuf_in_if.sv
`timescale 1ns / 1ps
// Input channel: one operation word per handshake.
// Depends on tobuf_pkg.
interface tobuf_in_if
  import tobuf_pkg::*;
;
  logic                valid;
  logic                ready;
  func_t               func;
  logic [TIME_W-1:0]   start_time;
  logic [TIME_W-1:0]   end_time;
  logic [TAG_W-1:0]    packet_tag;

  modport source (output valid, func, start_time, end_time, packet_tag, input ready);
  modport sink   (input valid, func, start_time, end_time, packet_tag, output ready);
endinterface

### rtl/tobuf_out_if.sv
`timescale 1ns / 1ps
// Result channel: one result word per handshake.
// Depends on tobuf_pkg.
interface tobuf_out_if
  import tobuf_pkg::*;
;
  logic                valid;
  logic                ready;
  status_t             status;
  logic [TAG_W-1:0]    out_tag;
  logic [TIME_W-1:0]   out_start;
  logic [TIME_W-1:0]   out_end;
  logic [CNT_W-1:0]    removed_count;
  logic                last;

  modport source (output valid, status, out_tag, out_start, out_end, removed_count, last,
                  input ready);
  modport sink   (input valid, status, out_tag, out_start, out_end, removed_count, last,
                  output ready);
endinterface

### rtl/tobuf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tobuf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tobuf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the packet buffer: walks the entry RAM one slot per step for
// insert, expire and range query, and holds the result register.
// Depends on tobuf_pkg, tobuf_in_if, tobuf_out_if.
module tobuf_ctrl
  import tobuf_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int SB       = TAG_W,
  parameter int AW       = $clog2(CAPACITY),
  parameter int EW       = 2 * TIME_W + SB
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  max_entries,
  tobuf_in_if.sink          in_ch,
  tobuf_out_if.source       out_ch,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [EW-1:0]     ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [EW-1:0]     ram_rdata
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INS0    = 5'd1;
  localparam logic [4:0] S_INS1    = 5'd2;
  localparam logic [4:0] S_INS2    = 5'd3;
  localparam logic [4:0] S_SRCH_RD = 5'd4;
  localparam logic [4:0] S_SRCH_CK = 5'd5;
  localparam logic [4:0] S_COPY_RD = 5'd6;
  localparam logic [4:0] S_COPY_WR = 5'd7;
  localparam logic [4:0] S_FINAL   = 5'd8;
  localparam logic [4:0] S_RES     = 5'd9;
  localparam logic [4:0] S_EXP_RD  = 5'd10;
  localparam logic [4:0] S_EXP_CK  = 5'd11;
  localparam logic [4:0] S_Q0      = 5'd12;
  localparam logic [4:0] S_QS_RD   = 5'd13;
  localparam logic [4:0] S_QS_CK   = 5'd14;
  localparam logic [4:0] S_QB_CK   = 5'd15;
  localparam logic [4:0] S_QI      = 5'd16;
  localparam logic [4:0] S_QL_CK   = 5'd17;
  localparam logic [4:0] S_QG_RD   = 5'd18;
  localparam logic [4:0] S_QG_CK   = 5'd19;
  localparam logic [4:0] S_QJ      = 5'd20;
  localparam logic [4:0] S_HIT_RD  = 5'd21;
  localparam logic [4:0] S_HIT     = 5'd22;

  logic [4:0]        state_r, state_nxt;
  logic [TIME_W-1:0] s_r, s_nxt, e_r, e_nxt;
  logic [SB-1:0]     t_r, t_nxt;
  logic [CW-1:0]     n_r, n_nxt, k_r, k_nxt, w_r, w_nxt, i0_r, i0_nxt, i1_r, i1_nxt;
  logic [CW-1:0]     dst_r, dst_nxt, cnt_r, cnt_nxt, pos_r, pos_nxt, nfin_r, nfin_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic              down_r, down_nxt, back_r, back_nxt, one_r, one_nxt;
  status_t           sts_r, sts_nxt;

  logic              ov_r, ov_nxt, olast_r, olast_nxt;
  status_t           osts_r, osts_nxt;
  logic [TAG_W-1:0]  otag_r, otag_nxt;
  logic [TIME_W-1:0] ostart_r, ostart_nxt, oend_r, oend_nxt;
  logic [CNT_W-1:0]  orem_r, orem_nxt;

  logic [TIME_W-1:0] rd_start, rd_end;
  logic [SB-1:0]     rd_tag;
  logic [CNT_W-1:0]  lim;
  logic              full, can_emit, hit_last;
  logic [CW-1:0]     raddr_c, waddr_c;

  assign rd_tag   = ram_rdata[SB-1:0];
  assign rd_end   = ram_rdata[SB+TIME_W-1:SB];
  assign rd_start = ram_rdata[SB+2*TIME_W-1:SB+TIME_W];

  // limit 0 makes every insert into a non-empty buffer see a full buffer
  assign lim      = (max_entries > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : max_entries;
  assign full     = CNT_W'(n_r) >= lim;
  assign can_emit = !ov_r || out_ch.ready;
  assign hit_last = one_r || (k_r + CW'(1) == i1_r) || (e_r <= rd_end);

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = ov_r;
  assign out_ch.status        = osts_r;
  assign out_ch.out_tag       = otag_r;
  assign out_ch.out_start     = ostart_r;
  assign out_ch.out_end       = oend_r;
  assign out_ch.removed_count = orem_r;
  assign out_ch.last          = olast_r;

  assign ram_raddr = raddr_c[AW-1:0];
  assign ram_waddr = waddr_c[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    s_nxt = s_r; e_nxt = e_r; t_nxt = t_r;
    n_nxt = n_r; k_nxt = k_r; w_nxt = w_r; i0_nxt = i0_r; i1_nxt = i1_r;
    dst_nxt = dst_r; cnt_nxt = cnt_r; pos_nxt = pos_r; nfin_nxt = nfin_r;
    rem_nxt = rem_r; down_nxt = down_r; back_nxt = back_r; one_nxt = one_r;
    sts_nxt = sts_r;
    ov_nxt = ov_r && !out_ch.ready;
    olast_nxt = olast_r; osts_nxt = osts_r; otag_nxt = otag_r;
    ostart_nxt = ostart_r; oend_nxt = oend_r; orem_nxt = orem_r;
    ram_we = 1'b0; waddr_c = '0; ram_wdata = ram_rdata;
    ram_re = 1'b0; raddr_c = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          s_nxt   = in_ch.start_time;
          e_nxt   = in_ch.end_time;
          t_nxt   = in_ch.packet_tag[SB-1:0];
          k_nxt   = '0;
          w_nxt   = '0;
          rem_nxt = '0;
          unique case (in_ch.func)
            FN_INSERT: state_nxt = S_INS0;
            FN_EXPIRE: state_nxt = S_EXP_RD;
            FN_QUERY:  state_nxt = S_Q0;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end

      S_INS0: begin
        if (n_r == '0) begin
          pos_nxt = '0; nfin_nxt = CW'(1); sts_nxt = STS_BACK;
          state_nxt = S_FINAL;
        end else begin
          ram_re = 1'b1; raddr_c = n_r - CW'(1);
          state_nxt = S_INS1;
        end
      end

      S_INS1: begin
        back_nxt = (s_r >= rd_end) || (s_r > rd_start);
        ram_re = 1'b1; raddr_c = '0;
        state_nxt = S_INS2;
      end

      S_INS2: begin
        if (back_r) begin
          sts_nxt = STS_BACK; down_nxt = 1'b1; dst_nxt = '0;
          if (full) begin
            cnt_nxt = n_r - CW'(1); pos_nxt = n_r - CW'(1); nfin_nxt = n_r;
          end else begin
            cnt_nxt = '0; pos_nxt = n_r; nfin_nxt = n_r + CW'(1);
          end
          state_nxt = S_COPY_RD;
        end else if (s_r == rd_start) begin
          sts_nxt = STS_DUP; state_nxt = S_RES;
        end else if (s_r < rd_start && full) begin
          sts_nxt = STS_OLD; state_nxt = S_RES;
        end else if (s_r < rd_start && e_r <= rd_start) begin
          sts_nxt = STS_FRONT; down_nxt = 1'b0; dst_nxt = n_r; cnt_nxt = n_r;
          pos_nxt = '0; nfin_nxt = n_r + CW'(1);
          state_nxt = S_COPY_RD;
        end else begin
          k_nxt = '0; state_nxt = S_SRCH_RD;
        end
      end

      S_SRCH_RD: begin
        ram_re = 1'b1; raddr_c = k_r;
        state_nxt = S_SRCH_CK;
      end

      S_SRCH_CK: begin
        sts_nxt = STS_MIDDLE;
        if (rd_start >= s_r) begin
          if (rd_start == s_r) begin
            sts_nxt = STS_DUP; state_nxt = S_RES;
          end else if (!full) begin
            down_nxt = 1'b0; dst_nxt = n_r; cnt_nxt = n_r - k_r;
            pos_nxt = k_r; nfin_nxt = n_r + CW'(1);
            state_nxt = S_COPY_RD;
          end else if (k_r == '0) begin
            // placed and dropped again at once
            state_nxt = S_RES;
          end else begin
            down_nxt = 1'b1; dst_nxt = '0; cnt_nxt = k_r - CW'(1);
            pos_nxt = k_r - CW'(1); nfin_nxt = n_r;
            state_nxt = S_COPY_RD;
          end
        end else if (k_r + CW'(1) == n_r) begin
          sts_nxt = STS_DUP; state_nxt = S_RES;
        end else begin
          k_nxt = k_r + CW'(1); state_nxt = S_SRCH_RD;
        end
      end

      S_COPY_RD: begin
        if (cnt_r == '0) begin
          state_nxt = S_FINAL;
        end else begin
          ram_re = 1'b1;
          raddr_c = down_r ? dst_r + CW'(1) : dst_r - CW'(1);
          state_nxt = S_COPY_WR;
        end
      end

      S_COPY_WR: begin
        ram_we = 1'b1; waddr_c = dst_r; ram_wdata = ram_rdata;
        dst_nxt = down_r ? dst_r + CW'(1) : dst_r - CW'(1);
        cnt_nxt = cnt_r - CW'(1);
        state_nxt = S_COPY_RD;
      end

      S_FINAL: begin
        ram_we = 1'b1; waddr_c = pos_r; ram_wdata = {s_r, e_r, t_r};
        n_nxt = nfin_r;
        state_nxt = S_RES;
      end

      S_RES: begin
        if (can_emit) begin
          ov_nxt = 1'b1; osts_nxt = sts_r; otag_nxt = '0; ostart_nxt = '0;
          oend_nxt = '0; orem_nxt = CNT_W'(rem_r); olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_EXP_RD: begin
        if (k_r == n_r) begin
          rem_nxt = n_r - w_r; n_nxt = w_r; sts_nxt = STS_EXPIRE;
          state_nxt = S_RES;
        end else begin
          ram_re = 1'b1; raddr_c = k_r;
          state_nxt = S_EXP_CK;
        end
      end

      S_EXP_CK: begin
        if (!(rd_end < s_r)) begin
          ram_we = 1'b1; waddr_c = w_r; ram_wdata = ram_rdata;
          w_nxt = w_r + CW'(1);
        end
        k_nxt = k_r + CW'(1);
        state_nxt = S_EXP_RD;
      end

      S_Q0: begin
        if (e_r < s_r) begin
          sts_nxt = STS_BADRNG; state_nxt = S_RES;
        end else if (n_r == '0) begin
          sts_nxt = STS_EMPTY; state_nxt = S_RES;
        end else begin
          k_nxt = '0; state_nxt = S_QS_RD;
        end
      end

      S_QS_RD: begin
        ram_re = 1'b1; raddr_c = k_r;
        state_nxt = S_QS_CK;
      end

      S_QS_CK: begin
        if (rd_start >= s_r) begin
          i0_nxt = k_r;
          if (k_r != '0 && rd_start > s_r) begin
            ram_re = 1'b1; raddr_c = k_r - CW'(1);
            state_nxt = S_QB_CK;
          end else begin
            state_nxt = S_QI;
          end
        end else if (k_r + CW'(1) == n_r) begin
          sts_nxt = STS_EMPTY; state_nxt = S_RES;
        end else begin
          k_nxt = k_r + CW'(1); state_nxt = S_QS_RD;
        end
      end

      S_QB_CK: begin
        // the entry before may still overlap the query start
        if (!(rd_end < s_r)) begin
          i0_nxt = i0_r - CW'(1);
        end
        state_nxt = S_QI;
      end

      S_QI: begin
        if (s_r == e_r) begin
          one_nxt = 1'b1; k_nxt = i0_r; state_nxt = S_HIT_RD;
        end else begin
          ram_re = 1'b1; raddr_c = n_r - CW'(1);
          state_nxt = S_QL_CK;
        end
      end

      S_QL_CK: begin
        if (e_r < rd_start) begin
          k_nxt = '0; state_nxt = S_QG_RD;
        end else begin
          i1_nxt = n_r; state_nxt = S_QJ;
        end
      end

      S_QG_RD: begin
        ram_re = 1'b1; raddr_c = k_r;
        state_nxt = S_QG_CK;
      end

      S_QG_CK: begin
        if (rd_start > e_r) begin
          i1_nxt = k_r; state_nxt = S_QJ;
        end else if (k_r + CW'(1) == n_r) begin
          i1_nxt = n_r; state_nxt = S_QJ;
        end else begin
          k_nxt = k_r + CW'(1); state_nxt = S_QG_RD;
        end
      end

      S_QJ: begin
        k_nxt = i0_r;
        if (i0_r == i1_r) begin
          one_nxt = 1'b1; state_nxt = S_HIT_RD;
        end else if (i1_r < i0_r) begin
          sts_nxt = STS_EMPTY; state_nxt = S_RES;
        end else begin
          one_nxt = 1'b0; state_nxt = S_HIT_RD;
        end
      end

      S_HIT_RD: begin
        ram_re = 1'b1; raddr_c = k_r;
        state_nxt = S_HIT;
      end

      S_HIT: begin
        if (can_emit) begin
          ov_nxt = 1'b1; osts_nxt = STS_HIT; otag_nxt = TAG_W'(rd_tag);
          ostart_nxt = rd_start; oend_nxt = rd_end; orem_nxt = '0;
          olast_nxt = hit_last;
          k_nxt = k_r + CW'(1);
          state_nxt = hit_last ? S_IDLE : S_HIT_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt; e_r <= e_nxt; t_r <= t_nxt;
    k_r <= k_nxt; w_r <= w_nxt; i0_r <= i0_nxt; i1_r <= i1_nxt;
    dst_r <= dst_nxt; cnt_r <= cnt_nxt; pos_r <= pos_nxt; nfin_r <= nfin_nxt;
    rem_r <= rem_nxt; down_r <= down_nxt; back_r <= back_nxt; one_r <= one_nxt;
    sts_r <= sts_nxt;
    olast_r <= olast_nxt; osts_r <= osts_nxt; otag_r <= otag_nxt;
    ostart_r <= ostart_nxt; oend_r <= oend_nxt; orem_r <= orem_nxt;
  end

endmodule

### rtl/time_ordered_packet_buffer_unit.sv
`timescale 1ns / 1ps
// Top level of the time-ordered packet buffer: limit register, sequencer,
// entry RAM. Depends on tobuf_pkg, tobuf_in_if, tobuf_out_if, tobuf_ctrl, tobuf_ram.
//
//  channel  dir  handshake        word
//  in_ch    in   valid/ready      func, start_time, end_time, packet_tag
//  out_ch   out  valid/ready      status, out_tag, out_start, out_end, removed_count, last
//  cfg      in   cfg_we           cfg_wdata (max_entries)
//
// One operation at a time; in_ch.ready is high only while idle.
// Insert: a search that reads the searched slots one by one, then one RAM read and
// one write per shifted slot. Expire: one read of each entry, with a write back of
// each entry kept. Query: one pass over the RAM per search plus one read per hit;
// all walks are set by the single read port of the entry RAM.
// Synchronous reset empties the buffer and sets max_entries to 64.
// A stalled out_ch holds the sequencer at its next result.
module time_ordered_packet_buffer_unit
  import tobuf_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  tobuf_in_if.sink         in_ch,
  tobuf_out_if.source      out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int SB = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = 2 * TIME_W + SB;

  logic [CNT_W-1:0] max_r;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [EW-1:0]    ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_ENTRIES_RST;
    end else if (cfg_we) begin
      max_r <= cfg_wdata;
    end
  end

  tobuf_ctrl #(
    .CAPACITY (CAPACITY),
    .SB       (SB),
    .AW       (AW),
    .EW       (EW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_entries (max_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  tobuf_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
